/* src/mroe_pkg.sv */
// Shared constants, opcodes and types of the matrix row operation engine.
package mroe_pkg;

  localparam int unsigned ROWS   = 64;
  localparam int unsigned COLS   = 64;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLS);
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned CNT_W  = $clog2(COLS + 1);
  localparam int unsigned DEPTH  = ROWS * COLS;

  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd4;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned PADDR_W    = 3;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;
  localparam logic              CFG_IDX_COLS = 1'b0;

  typedef struct packed {
    logic            capture;
    logic [OP_W-1:0] op;
  } mroe_dp_ctrl_t;

endpackage

/* src/matrix_row_operation_engine_core.sv */
// Matrix row operation engine: top level with sequencer, result register and APB port.
//
// Holds a 64 x 64 matrix of 32-bit elements. Each request on the input channel
// (in_valid_i / in_stall_o) carries an opcode: write element, read element, swap
// rows, scale row, or add a scalar multiple of row_a to row_b. Every request gives
// one result on the output channel (out_valid_o / out_stall_i): read_data_o and
// bad_column_o. cols_in_use sits at APB address 0 and bounds both row operations
// and element accesses; write it only while the engine is idle.
// One request is handled at a time by a sequencer over the shared memory and one
// multiply-add unit. A write loads the result directly and a read goes through the
// registered memory read; a row operation takes, for each column in use, one memory
// read, one capture and one write, plus a second write for swap. A bad-column
// access, an unused opcode or a row operation with no columns in use goes straight to
// the result. The next request can be taken in the cycle after the result is loaded,
// while that result waits. If the receiver stalls, the result holds and the following
// request finishes only once the result register is free.
// After reset the engine clears every element of the store, one element a cycle,
// with in_stall_o high; configuration writes are taken throughout.
module matrix_row_operation_engine_core
  import mroe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [ROW_W-1:0]         row_a_i,
  input  logic [ROW_W-1:0]         row_b_i,
  input  logic [COL_W-1:0]         column_i,
  input  logic signed [ELEM_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEM_W-1:0] read_data_o,
  output logic                     bad_column_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EX   = 3'd3;
  localparam logic [2:0] ST_WR1  = 3'd4;
  localparam logic [2:0] ST_WR2  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [ROW_W-1:0]  ra_q, ra_d;
  logic [ROW_W-1:0]  rb_q, rb_d;
  logic [ELEM_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ELEM_W-1:0] res_data_q, res_data_d;
  logic              res_bad_q, res_bad_d;
  logic              out_valid_q, out_valid_d;
  logic [ELEM_W-1:0] out_data_q;
  logic              out_bad_q;
  logic [CFG_W-1:0]  cols_q;

  logic [CNT_W-1:0]  n_eff;
  logic              in_accept;
  logic              bad_col;
  logic              out_free;
  logic              load_out;
  logic              last_col;
  logic              cfg_wr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [ELEM_W-1:0] rd_data_a;
  logic [ELEM_W-1:0] rd_data_b;
  logic [ELEM_W-1:0] wdata_first;
  logic [ELEM_W-1:0] wdata_second;
  mroe_dp_ctrl_t     dp_ctrl;

  assign n_eff     = (cols_q > CFG_W'(COLS)) ? CNT_W'(COLS) : CNT_W'(cols_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign bad_col   = (CNT_W'(column_i) >= n_eff);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DONE) && out_free;
  assign last_col  = ((j_q + CNT_W'(1)) == n_eff);

  assign dp_ctrl.capture = (state_q == ST_EX);
  assign dp_ctrl.op      = op_q;

  mroe_store u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  mroe_datapath u_datapath (
    .clk_i          (clk_i),
    .ctrl_i         (dp_ctrl),
    .a_data_i       (rd_data_a),
    .b_data_i       (rd_data_b),
    .scalar_i       (val_q),
    .wdata_first_o  (wdata_first),
    .wdata_second_o (wdata_second)
  );

  always_comb begin
    rd_addr_a = {ra_q, j_q[COL_W-1:0]};
    rd_addr_b = {rb_q, j_q[COL_W-1:0]};
    if (state_q == ST_IDLE) begin
      rd_addr_a = {row_a_i, column_i};
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {ra_q, j_q[COL_W-1:0]};
    wr_data = wdata_first;
    case (state_q)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      ST_IDLE: begin
        wr_en   = in_accept && (opcode_i == OP_WRITE) && !bad_col;
        wr_addr = {row_a_i, column_i};
        wr_data = value_i;
      end
      ST_WR1: begin
        wr_en = 1'b1;
        if (op_q == OP_ADD) begin
          wr_addr = {rb_q, j_q[COL_W-1:0]};
        end
      end
      ST_WR2: begin
        wr_en   = 1'b1;
        wr_addr = {rb_q, j_q[COL_W-1:0]};
        wr_data = wdata_second;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    val_d      = val_q;
    j_d        = j_q;
    clr_d      = clr_q;
    res_data_d = res_data_q;
    res_bad_d  = res_bad_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_d       = opcode_i;
          ra_d       = row_a_i;
          rb_d       = row_b_i;
          val_d      = value_i;
          j_d        = '0;
          res_data_d = '0;
          res_bad_d  = 1'b0;
          state_d    = ST_DONE;
          case (opcode_i)
            OP_WRITE: res_bad_d = bad_col;
            OP_READ: begin
              res_bad_d = bad_col;
              if (!bad_col) begin
                state_d = ST_EX;
              end
            end
            OP_SWAP, OP_SCALE, OP_ADD: begin
              if (n_eff != '0) begin
                state_d = ST_RD;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RD: state_d = ST_EX;
      ST_EX: begin
        if (op_q == OP_READ) begin
          res_data_d = rd_data_a;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_WR1;
        end
      end
      ST_WR1, ST_WR2: begin
        if ((state_q == ST_WR1) && (op_q == OP_SWAP)) begin
          state_d = ST_WR2;
        end else if (last_col) begin
          state_d = ST_DONE;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    val_q      <= val_d;
    j_q        <= j_d;
    res_data_q <= res_data_d;
    res_bad_q  <= res_bad_d;
    if (load_out) begin
      out_data_q <= res_data_q;
      out_bad_q  <= res_bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign bad_column_o = out_bad_q;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
    end else if (cfg_wr) begin
      cols_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_COLS) ? {{(32-CFG_W){1'b0}}, cols_q} : '0;

endmodule

/* src/mroe_store.sv */
// Matrix element memory: one write port, two registered read ports.
module mroe_store
  import mroe_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ELEM_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output logic [ELEM_W-1:0] rd_data_a_o,
  output logic [ELEM_W-1:0] rd_data_b_o
);

  logic [ELEM_W-1:0] mem_q [DEPTH];
  logic [ELEM_W-1:0] rd_a_q;
  logic [ELEM_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

/* src/mroe_datapath.sv */
// Shared multiply and add unit for the row operations.
module mroe_datapath
  import mroe_pkg::*;
(
  input  logic              clk_i,
  input  mroe_dp_ctrl_t     ctrl_i,
  input  logic [ELEM_W-1:0] a_data_i,
  input  logic [ELEM_W-1:0] b_data_i,
  input  logic [ELEM_W-1:0] scalar_i,
  output logic [ELEM_W-1:0] wdata_first_o,
  output logic [ELEM_W-1:0] wdata_second_o
);

  logic [ELEM_W-1:0] a_q;
  logic [ELEM_W-1:0] b_q;
  logic [ELEM_W-1:0] prod_q;
  logic [ELEM_W-1:0] prod_d;

  assign prod_d = ELEM_W'(a_data_i * scalar_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      a_q    <= a_data_i;
      b_q    <= b_data_i;
      prod_q <= prod_d;
    end
  end

  always_comb begin
    case (ctrl_i.op)
      OP_SWAP:  wdata_first_o = b_q;
      OP_SCALE: wdata_first_o = prod_q;
      OP_ADD:   wdata_first_o = b_q + prod_q;
      default:  wdata_first_o = b_q;
    endcase
  end

  assign wdata_second_o = a_q;

endmodule

/* src/mroe_checker.sv */
// Port-level checks for the matrix row operation engine, bound to the top level.
module mroe_assertions
  import mroe_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ELEM_W-1:0] read_data_o,
  input logic              bad_column_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(bad_column_o))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // stall requests during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken before store cleared");

  // drop read data on a bad column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_column_o |-> read_data_o == '0)
    else $error("bad column with non-zero data");

endmodule

bind matrix_row_operation_engine_core mroe_assertions u_mroe_assertions (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_data_o  (read_data_o),
  .bad_column_o (bad_column_o)
);
